[rtl/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// shared types, codes and sizes of the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int QueueDepthDef  = 16;
   localparam int StaticSlotsDef = 32;
   localparam int NumHandles     = 16;

   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_DEL  = 2'd1,
      CMD_TICK = 2'd2,
      CMD_ARM  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_SET_OK      = 3'd0,
      KIND_SET_FULL    = 3'd1,
      KIND_DELETED     = 3'd2,
      KIND_NOT_PENDING = 3'd3,
      KIND_ARMED       = 3'd4,
      KIND_TIMER_EXP   = 3'd5,
      KIND_STATIC_EXP  = 3'd6,
      KIND_NOTHING_DUE = 3'd7
   } kind_type;

   // one entry of the sorted list
   typedef struct packed {
      logic [3:0]  handle;
      logic [31:0] expiry;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  handle;
      logic [4:0]  slot;
      logic [31:0] arg;
   } result_type;

endpackage

[rtl/stq_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq interfaces
// command and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface stq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [3:0]  handle;
   logic [4:0]  slot;
   logic [31:0] expiry;
   logic [31:0] callback_arg;
   logic [31:0] now;

   modport source (output valid, cmd, handle, slot, expiry, callback_arg, now,
                   input ready);
   modport sink (input valid, cmd, handle, slot, expiry, callback_arg, now,
                 output ready);
endinterface

interface stq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  out_handle;
   logic [4:0]  out_slot;
   logic [31:0] out_arg;
   logic        last;

   modport source (output valid, kind, out_handle, out_slot, out_arg, last,
                   input ready);
   modport sink (input valid, kind, out_handle, out_slot, out_arg, last,
                 output ready);
endinterface

[rtl/stq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sorted_timer_queue.sv]
`timescale 1ns / 1ps
// set and delete walk the queued entries (the unlink and insert walks read one list entry a cycle);
// arm writes its static slot; tick handles each expired timer in turn, moves the remaining entries
// down to close the gap, then scans every static slot.
// throughput: one item at a time; the list memory port sets the pace.
// reset: synchronous; queue empty, no timer pending, no static slot active. no clearing pass.
// ----------------------------------------------------------------------------
// sorted_timer_queue
// timers kept in a list memory sorted by expiry, plus static slots
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
   parameter int QUEUE_DEPTH  = stq_pkg::QueueDepthDef,
   parameter int STATIC_SLOTS = stq_pkg::StaticSlotsDef
) (
   input  logic        clock,
   input  logic        reset,
   stq_req_if.sink     req_chan,
   stq_rsp_if.source   rsp_chan
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (STATIC_SLOTS > 1) ? $clog2(STATIC_SLOTS) : 1;
   localparam int EW = $bits(stq_pkg::entry_type);

   typedef enum logic [3:0] {
      ST_IDLE, ST_UNL, ST_SET_CHK, ST_INS, ST_INS_ZERO, ST_TK_RD, ST_TK_CHK,
      ST_TK_ARG, ST_TK_PUSH, ST_CMP, ST_SL_RD, ST_SL_CMP, ST_SL_PUSH, ST_FINAL
   } state_type;

   state_type                   state_ff, state_in;
   stq_pkg::cmd_type            cmd_ff, cmd_in;
   logic [3:0]                  hdl_ff, hdl_in;
   logic [31:0]                 exp_ff, exp_in;
   logic [31:0]                 arg_ff, arg_in;
   logic [31:0]                 now_ff, now_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [stq_pkg::NumHandles-1:0] pend_ff, pend_in;
   logic [STATIC_SLOTS-1:0]     active_ff, active_in;
   logic [CW-1:0]               widx_ff, widx_in;
   logic                        rvld_ff, rvld_in;
   logic [AW-1:0]               ridx_ff, ridx_in;
   logic                        found_ff, found_in;
   logic                        iss_ff, iss_in;
   logic [CW-1:0]               kcnt_ff, kcnt_in;
   logic [SW-1:0]               sidx_ff, sidx_in;
   stq_pkg::result_type         new_ff, new_in;
   stq_pkg::result_type         hold_ff, hold_in;
   logic                        hold_vld_ff, hold_vld_in;
   stq_pkg::result_type         rsp_ff, rsp_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_vld_ff, rsp_vld_in;

   logic                        ord_we, ord_re;
   logic [AW-1:0]               ord_wa, ord_ra;
   stq_pkg::entry_type          ord_wd, ord_rd;
   logic [EW-1:0]               ord_rd_raw;
   logic                        arg_we, arg_re;
   logic [3:0]                  arg_wa, arg_ra;
   logic [31:0]                 arg_wd, arg_rd;
   logic                        sl_we, sl_re;
   logic [SW-1:0]               sl_wa, sl_ra;
   logic [31:0]                 sl_wd, sl_rd;

   logic                        out_free;
   logic                        accept;
   stq_pkg::entry_type          new_entry;

   stq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_order_ram (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_en(ord_re), .rd_addr(ord_ra), .rd_data(ord_rd_raw)
   );

   stq_ram #(.WIDTH(32), .DEPTH(stq_pkg::NumHandles), .AW(4)) u_arg_ram (
      .clock(clock), .wr_en(arg_we), .wr_addr(arg_wa), .wr_data(arg_wd),
      .rd_en(arg_re), .rd_addr(arg_ra), .rd_data(arg_rd)
   );

   stq_ram #(.WIDTH(32), .DEPTH(STATIC_SLOTS), .AW(SW)) u_static_ram (
      .clock(clock), .wr_en(sl_we), .wr_addr(sl_wa), .wr_data(sl_wd),
      .rd_en(sl_re), .rd_addr(sl_ra), .rd_data(sl_rd)
   );

   assign ord_rd    = stq_pkg::entry_type'(ord_rd_raw);
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && (state_ff == ST_IDLE);
   assign new_entry = '{handle: hdl_ff, expiry: exp_ff};

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.kind       = rsp_ff.kind;
   assign rsp_chan.out_handle = rsp_ff.handle;
   assign rsp_chan.out_slot   = rsp_ff.slot;
   assign rsp_chan.out_arg    = rsp_ff.arg;
   assign rsp_chan.last       = rsp_last_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      hdl_in      = hdl_ff;
      exp_in      = exp_ff;
      arg_in      = arg_ff;
      now_in      = now_ff;
      count_in    = count_ff;
      pend_in     = pend_ff;
      active_in   = active_ff;
      widx_in     = widx_ff;
      rvld_in     = 1'b0;
      ridx_in     = ridx_ff;
      found_in    = found_ff;
      iss_in      = iss_ff;
      kcnt_in     = kcnt_ff;
      sidx_in     = sidx_ff;
      new_in      = new_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      rsp_in      = rsp_ff;
      rsp_last_in = rsp_last_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;

      ord_we = 1'b0;
      ord_wa = ridx_ff;
      ord_wd = ord_rd;
      ord_re = 1'b0;
      ord_ra = widx_ff[AW-1:0];
      arg_we = 1'b0;
      arg_wa = hdl_ff;
      arg_wd = arg_ff;
      arg_re = 1'b0;
      arg_ra = ord_rd.handle;
      sl_we  = 1'b0;
      sl_wa  = req_chan.slot[SW-1:0];
      sl_wd  = req_chan.expiry;
      sl_re  = 1'b0;
      sl_ra  = sidx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = stq_pkg::cmd_type'(req_chan.cmd);
               hdl_in   = req_chan.handle;
               exp_in   = req_chan.expiry;
               arg_in   = req_chan.callback_arg;
               now_in   = req_chan.now;
               widx_in  = '0;
               found_in = 1'b0;
               case (stq_pkg::cmd_type'(req_chan.cmd))
                  stq_pkg::CMD_SET: begin
                     state_in = pend_ff[req_chan.handle] ? ST_UNL : ST_SET_CHK;
                  end
                  stq_pkg::CMD_DEL: begin
                     if (pend_ff[req_chan.handle]) begin
                        state_in = ST_UNL;
                     end else begin
                        hold_in     = '{kind: stq_pkg::KIND_NOT_PENDING,
                                        handle: req_chan.handle, slot: '0, arg: '0};
                        hold_vld_in = 1'b1;
                        state_in    = ST_FINAL;
                     end
                  end
                  stq_pkg::CMD_TICK: begin
                     state_in = ST_TK_RD;
                  end
                  stq_pkg::CMD_ARM: begin
                     if (int'(req_chan.slot) < STATIC_SLOTS) begin
                        sl_we = 1'b1;
                        active_in[req_chan.slot[SW-1:0]] = 1'b1;
                     end
                     hold_in     = '{kind: stq_pkg::KIND_ARMED, handle: '0,
                                     slot: req_chan.slot, arg: '0};
                     hold_vld_in = 1'b1;
                     state_in    = ST_FINAL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // walk up the list, closing the gap left by the handle
         ST_UNL: begin
            if (widx_ff < count_ff) begin
               ord_re  = 1'b1;
               rvld_in = 1'b1;
               ridx_in = widx_ff[AW-1:0];
               widx_in = widx_ff + CW'(1);
            end
            if (rvld_ff) begin
               if (found_ff) begin
                  ord_we = 1'b1;
                  ord_wa = ridx_ff - AW'(1);
               end
               if (ord_rd.handle == hdl_ff) begin
                  found_in = 1'b1;
               end
               if (CW'(ridx_ff) == count_ff - CW'(1)) begin
                  rvld_in         = 1'b0;
                  count_in        = count_ff - CW'(1);
                  pend_in[hdl_ff] = 1'b0;
                  if (cmd_ff == stq_pkg::CMD_SET) begin
                     state_in = ST_SET_CHK;
                  end else begin
                     hold_in     = '{kind: stq_pkg::KIND_DELETED, handle: hdl_ff,
                                     slot: '0, arg: '0};
                     hold_vld_in = 1'b1;
                     state_in    = ST_FINAL;
                  end
               end
            end
         end

         ST_SET_CHK: begin
            if (count_ff >= CW'(QUEUE_DEPTH)) begin
               hold_in     = '{kind: stq_pkg::KIND_SET_FULL, handle: hdl_ff,
                               slot: '0, arg: '0};
               hold_vld_in = 1'b1;
               state_in    = ST_FINAL;
            end else begin
               arg_we = 1'b1;
               if (count_ff == '0) begin
                  state_in = ST_INS_ZERO;
               end else begin
                  widx_in  = count_ff - CW'(1);
                  iss_in   = 1'b1;
                  state_in = ST_INS;
               end
            end
         end

         // walk down the list, moving later entries up by one
         ST_INS: begin
            if (iss_ff) begin
               ord_re  = 1'b1;
               rvld_in = 1'b1;
               ridx_in = widx_ff[AW-1:0];
               if (widx_ff == '0) begin
                  iss_in = 1'b0;
               end else begin
                  widx_in = widx_ff - CW'(1);
               end
            end
            if (rvld_ff) begin
               ord_we = 1'b1;
               ord_wa = ridx_ff + AW'(1);
               if (ord_rd.expiry >= exp_ff) begin
                  if (ridx_ff == '0) begin
                     rvld_in  = 1'b0;
                     iss_in   = 1'b0;
                     state_in = ST_INS_ZERO;
                  end
               end else begin
                  ord_wd          = new_entry;
                  rvld_in         = 1'b0;
                  iss_in          = 1'b0;
                  count_in        = count_ff + CW'(1);
                  pend_in[hdl_ff] = 1'b1;
                  hold_in         = '{kind: stq_pkg::KIND_SET_OK, handle: hdl_ff,
                                      slot: '0, arg: '0};
                  hold_vld_in     = 1'b1;
                  state_in        = ST_FINAL;
               end
            end
         end

         ST_INS_ZERO: begin
            ord_we          = 1'b1;
            ord_wa          = '0;
            ord_wd          = new_entry;
            count_in        = count_ff + CW'(1);
            pend_in[hdl_ff] = 1'b1;
            hold_in         = '{kind: stq_pkg::KIND_SET_OK, handle: hdl_ff,
                                slot: '0, arg: '0};
            hold_vld_in     = 1'b1;
            state_in        = ST_FINAL;
         end

         ST_TK_RD: begin
            if (widx_ff < count_ff) begin
               ord_re   = 1'b1;
               state_in = ST_TK_CHK;
            end else begin
               kcnt_in  = widx_ff;
               count_in = '0;
               sidx_in  = '0;
               state_in = ST_SL_RD;
            end
         end

         ST_TK_CHK: begin
            if (ord_rd.expiry <= now_ff) begin
               arg_re                = 1'b1;
               pend_in[ord_rd.handle] = 1'b0;
               new_in.handle         = ord_rd.handle;
               widx_in               = widx_ff + CW'(1);
               state_in              = ST_TK_ARG;
            end else begin
               kcnt_in = widx_ff;
               if (widx_ff == '0) begin
                  sidx_in  = '0;
                  state_in = ST_SL_RD;
               end else begin
                  state_in = ST_CMP;
               end
            end
         end

         ST_TK_ARG: begin
            new_in   = '{kind: stq_pkg::KIND_TIMER_EXP, handle: new_ff.handle,
                         slot: '0, arg: arg_rd};
            state_in = ST_TK_PUSH;
         end

         ST_TK_PUSH: begin
            if (!hold_vld_ff) begin
               hold_in     = new_ff;
               hold_vld_in = 1'b1;
               state_in    = ST_TK_RD;
            end else if (out_free) begin
               rsp_in      = hold_ff;
               rsp_last_in = 1'b0;
               rsp_vld_in  = 1'b1;
               hold_in     = new_ff;
               state_in    = ST_TK_RD;
            end
         end

         // shift the remaining entries down past the expired ones
         ST_CMP: begin
            if (widx_ff < count_ff) begin
               ord_re  = 1'b1;
               rvld_in = 1'b1;
               ridx_in = widx_ff[AW-1:0];
               widx_in = widx_ff + CW'(1);
            end
            if (rvld_ff) begin
               ord_we = 1'b1;
               ord_wa = AW'(CW'(ridx_ff) - kcnt_ff);
               if (CW'(ridx_ff) == count_ff - CW'(1)) begin
                  rvld_in  = 1'b0;
                  count_in = count_ff - kcnt_ff;
                  sidx_in  = '0;
                  state_in = ST_SL_RD;
               end
            end
         end

         ST_SL_RD: begin
            if (active_ff[sidx_ff]) begin
               sl_re    = 1'b1;
               state_in = ST_SL_CMP;
            end else if (sidx_ff == SW'(STATIC_SLOTS - 1)) begin
               state_in = ST_FINAL;
            end else begin
               sidx_in = sidx_ff + SW'(1);
            end
         end

         ST_SL_CMP: begin
            if (sl_rd <= now_ff) begin
               active_in[sidx_ff] = 1'b0;
               new_in   = '{kind: stq_pkg::KIND_STATIC_EXP, handle: '0,
                            slot: 5'(sidx_ff), arg: '0};
               state_in = ST_SL_PUSH;
            end else if (sidx_ff == SW'(STATIC_SLOTS - 1)) begin
               state_in = ST_FINAL;
            end else begin
               sidx_in  = sidx_ff + SW'(1);
               state_in = ST_SL_RD;
            end
         end

         ST_SL_PUSH: begin
            if (!hold_vld_ff || out_free) begin
               if (hold_vld_ff) begin
                  rsp_in      = hold_ff;
                  rsp_last_in = 1'b0;
                  rsp_vld_in  = 1'b1;
               end
               hold_in     = new_ff;
               hold_vld_in = 1'b1;
               if (sidx_ff == SW'(STATIC_SLOTS - 1)) begin
                  state_in = ST_FINAL;
               end else begin
                  sidx_in  = sidx_ff + SW'(1);
                  state_in = ST_SL_RD;
               end
            end
         end

         ST_FINAL: begin
            if (out_free) begin
               if (hold_vld_ff) begin
                  rsp_in = hold_ff;
               end else begin
                  rsp_in = '{kind: stq_pkg::KIND_NOTHING_DUE, handle: '0,
                             slot: '0, arg: '0};
               end
               rsp_last_in = 1'b1;
               rsp_vld_in  = 1'b1;
               hold_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pend_ff     <= '0;
         active_ff   <= '0;
         rvld_ff     <= 1'b0;
         found_ff    <= 1'b0;
         iss_ff      <= 1'b0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pend_ff     <= pend_in;
         active_ff   <= active_in;
         rvld_ff     <= rvld_in;
         found_ff    <= found_in;
         iss_ff      <= iss_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      cmd_ff      <= cmd_in;
      hdl_ff      <= hdl_in;
      exp_ff      <= exp_in;
      arg_ff      <= arg_in;
      now_ff      <= now_in;
      widx_ff     <= widx_in;
      ridx_ff     <= ridx_in;
      kcnt_ff     <= kcnt_in;
      sidx_ff     <= sidx_in;
      new_ff      <= new_in;
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
